[src/ipsv_pkg.sv]
// Shared types and constants for the inverse Park / space vector PWM block.
// Holds the word formats, the fixed-point constants and the sector codes.
// No dependencies.
package ipsv_pkg;

    // Angle resolution: the low ANGLE_BITS bits of the angle field form one turn.
    localparam int ANGLE_BITS = 16;

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Back pipeline layout.
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 15;
    localparam int UREF_STAGE = SQRT_STEPS + DIV_STEPS + 2;
    localparam int PIPE_LAST  = UREF_STAGE + 2;
    localparam int SIN_DEPTH  = 6;

    // Configuration register indexes and reset values.
    localparam logic [0:0]  REG_SUPPLY    = 1'b0;
    localparam logic [0:0]  REG_PERIOD    = 1'b1;
    localparam logic [15:0] SUPPLY_RESET  = 16'd3072;
    localparam logic [15:0] PERIOD_RESET  = 16'd100;

    // Modulation index limit (0.577 in Q1.15) and one PWM period in Q1.15.
    localparam logic [14:0] UREF_MAX   = 15'd18907;
    localparam logic [14:0] UREF_LIMIT = 15'd18908;
    localparam logic [16:0] ONE_Q15    = 17'd32768;
    localparam logic [16:0] FULL_FRAC  = 17'd65536;

    // Odd polynomial for sqrt(3) * sin(x * 60 degrees), Q30 coefficients.
    localparam logic [31:0] C1_Q30 = 32'd1947552238;
    localparam logic [31:0] C3_Q30 = 32'd355954997;
    localparam logic [31:0] C5_Q30 = 32'd19517417;
    localparam logic [31:0] C7_Q30 = 32'd509601;
    localparam logic [31:0] C9_Q30 = 32'd7762;

    // Sector codes (sector number minus one).
    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;

    typedef struct packed {
        logic signed [15:0] volt_q;
        logic signed [15:0] volt_d;
        logic [15:0]        elec_angle;
    } ipsv_in_t;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [2:0]  sector_index;
    } ipsv_out_t;

    // Classified word handed from the front to the back.
    typedef struct packed {
        logic [31:0] mag_sq;
        logic [2:0]  sector;
        logic [15:0] frac;
    } ipsv_work_t;

endpackage

[src/inverse_park_svpwm.sv]
// An accepted word passes the front holding register, the queue and the back
// pipeline. One word per cycle unless out_stall holds a finished word; each
// back stage, the bit-per-stage square root and divider too, takes a new word.
// Reset: bus voltage returns to 3072 (12 V), PWM period to 100; the queue
// and the pipeline empty at once.
module inverse_park_svpwm
    import ipsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  ipsv_in_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output ipsv_out_t   out_data,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] supply_voltage_reg, supply_voltage_next;
    logic [15:0] timer_period_reg, timer_period_next;
    logic        wr_valid, full, rd_en, rd_valid;
    ipsv_work_t  wr_data, rd_data;

    // Configuration register writes.
    always_comb
    begin
        supply_voltage_next = supply_voltage_reg;
        timer_period_next   = timer_period_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SUPPLY: supply_voltage_next = cfg_data;
                REG_PERIOD: timer_period_next   = cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_voltage_reg <= SUPPLY_RESET;
            timer_period_reg   <= PERIOD_RESET;
        end
        else
        begin
            supply_voltage_reg <= supply_voltage_next;
            timer_period_reg   <= timer_period_next;
        end
    end

    // Front end, queue and back pipeline.
    ipsv_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .wr_valid (wr_valid),
        .wr_data  (wr_data),
        .full     (full)
    );

    ipsv_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_data  (wr_data),
        .full     (full),
        .rd_en    (rd_en),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    ipsv_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .rd_valid       (rd_valid),
        .rd_data        (rd_data),
        .rd_en          (rd_en),
        .supply_voltage (supply_voltage_reg),
        .timer_period   (timer_period_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data)
    );

endmodule

[src/ipsv_front.sv]
// Front end: accepts input words, squares the voltage commands and splits
// the shifted angle into sector and fraction. Depends on ipsv_pkg.
module ipsv_front
    import ipsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  ipsv_in_t   in_data,
    output logic       wr_valid,
    output ipsv_work_t wr_data,
    input  logic       full
);

    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS - 2){1'b0}}};

    logic                  fv_reg, fv_next;
    ipsv_work_t            item_reg, item_next;
    logic                  accept;
    logic [15:0]           raw_q, raw_d, mag_q, mag_d;
    logic [31:0]           sq_q, sq_d;
    logic [ANGLE_BITS-1:0] ang, theta, phi;
    logic [ANGLE_BITS+2:0] x6;
    logic [15:0]           frac;

    // Magnitudes of the two commands and the sum of their squares.
    always_comb
    begin
        raw_q = in_data.volt_q;
        raw_d = in_data.volt_d;
        mag_q = raw_q[15] ? (16'd0 - raw_q) : raw_q;
        mag_d = raw_d[15] ? (16'd0 - raw_d) : raw_d;
        sq_q  = {16'd0, mag_q} * {16'd0, mag_q};
        sq_d  = {16'd0, mag_d} * {16'd0, mag_d};
    end

    // Only the low angle bits take part.
    generate
        if (ANGLE_BITS <= 16)
        begin : g_ang_narrow
            assign ang = in_data.elec_angle[ANGLE_BITS-1:0];
        end
        else
        begin : g_ang_wide
            assign ang = {{(ANGLE_BITS - 16){1'b0}}, in_data.elec_angle};
        end
    endgenerate

    // The vector leads the angle by a quarter turn; six sectors per turn.
    always_comb
    begin
        theta = ang + QUARTER;
        x6    = ({3'b000, theta} << 2) + ({3'b000, theta} << 1);
        phi   = x6[ANGLE_BITS-1:0];
    end

    // Fraction through the sector as a 16-bit value.
    generate
        if (ANGLE_BITS >= 16)
        begin : g_frac_trunc
            assign frac = phi[ANGLE_BITS-1:ANGLE_BITS-16];
        end
        else
        begin : g_frac_pad
            assign frac = {phi, {(16 - ANGLE_BITS){1'b0}}};
        end
    endgenerate

    // Holding register toward the queue.
    always_comb
    begin
        in_stall  = fv_reg && full;
        accept    = in_valid && !in_stall;
        fv_next   = fv_reg;
        item_next = item_reg;
        if (accept)
        begin
            fv_next          = 1'b1;
            item_next.mag_sq = sq_q + sq_d;
            item_next.sector = x6[ANGLE_BITS+2:ANGLE_BITS];
            item_next.frac   = frac;
        end
        else if (fv_reg && !full)
        begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign wr_valid = fv_reg;
    assign wr_data  = item_reg;

endmodule

[src/ipsv_fifo.sv]
// Short queue that decouples the front end from the back pipeline.
// Depends on ipsv_pkg for the word type and depth.
module ipsv_fifo
    import ipsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_valid,
    input  ipsv_work_t wr_data,
    output logic       full,
    input  logic       rd_en,
    output logic       rd_valid,
    output ipsv_work_t rd_data
);

    ipsv_work_t         mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               push, pop;

    // Pointer and fill count update.
    always_comb
    begin
        full        = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
        rd_valid    = (count_reg != '0);
        push        = wr_valid && !full;
        pop         = rd_en && rd_valid;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        rd_data = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("queue fill count above depth");

    // The pointer distance tracks the fill count.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (FIFO_AW'(wr_ptr_reg - rd_ptr_reg)) == count_reg[FIFO_AW-1:0])
        else $error("queue pointers disagree with fill count");

    // A word is only taken out of a queue that holds one.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");

endmodule

[src/ipsv_sin60.sv]
// Pipelined evaluation of sqrt(3) * sin(x * 60 degrees) in Q30 by Horner steps.
// Six register stages, one multiplier each. Depends on ipsv_pkg.
module ipsv_sin60
    import ipsv_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [16:0] arg,
    output logic [31:0] g
);

    logic [16:0] a_reg  [1:5];
    logic [31:0] f2_reg [1:4];
    logic [31:0] p_reg  [2:5];
    logic [31:0] g_reg;

    logic [33:0] sqr;
    logic [63:0] m2, m3, m4, m5;
    logic [48:0] m6;
    logic [31:0] f2_next, p2_next, p3_next, p4_next, p5_next, g_next;

    // One multiply per stage.
    always_comb
    begin
        sqr     = {17'd0, arg} * {17'd0, arg};
        f2_next = sqr[33:2];
        m2      = {32'd0, f2_reg[1]} * {32'd0, C9_Q30};
        p2_next = C7_Q30 - m2[61:30];
        m3      = {32'd0, f2_reg[2]} * {32'd0, p_reg[2]};
        p3_next = C5_Q30 - m3[61:30];
        m4      = {32'd0, f2_reg[3]} * {32'd0, p_reg[3]};
        p4_next = C3_Q30 - m4[61:30];
        m5      = {32'd0, f2_reg[4]} * {32'd0, p_reg[4]};
        p5_next = C1_Q30 - m5[61:30];
        m6      = {32'd0, a_reg[5]} * {17'd0, p_reg[5]};
        g_next  = m6[47:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[1]  <= arg;
            a_reg[2]  <= a_reg[1];
            a_reg[3]  <= a_reg[2];
            a_reg[4]  <= a_reg[3];
            a_reg[5]  <= a_reg[4];
            f2_reg[1] <= f2_next;
            f2_reg[2] <= f2_reg[1];
            f2_reg[3] <= f2_reg[2];
            f2_reg[4] <= f2_reg[3];
            p_reg[2]  <= p2_next;
            p_reg[3]  <= p3_next;
            p_reg[4]  <= p4_next;
            p_reg[5]  <= p5_next;
            g_reg     <= g_next;
        end
    end

    assign g = g_reg;

endmodule

[src/ipsv_back.sv]
// Back pipeline: square root, clamped division by the bus voltage, sector
// times and duty scaling. Depends on ipsv_pkg and ipsv_sin60.
module ipsv_back
    import ipsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_valid,
    input  ipsv_work_t  rd_data,
    output logic        rd_en,
    input  logic [15:0] supply_voltage,
    input  logic [15:0] timer_period,
    output logic        out_valid,
    input  logic        out_stall,
    output ipsv_out_t   out_data
);

    localparam int SAT_STAGE = SQRT_STEPS + 1;

    logic              en;
    logic              vld_reg [0:PIPE_LAST];
    logic              out_valid_reg;
    ipsv_out_t         out_data_reg, out_data_next;

    logic [31:0]       s_p0_reg;
    logic [15:0]       f_p0_reg;
    logic [2:0]        sec_reg [0:PIPE_LAST];

    logic [62:0]       sq_rem_reg  [1:SQRT_STEPS];
    logic [30:0]       sq_root_reg [1:SQRT_STEPS];

    logic [30:0]       dv_rem_reg [SAT_STAGE:SAT_STAGE+DIV_STEPS];
    logic [14:0]       dv_quo_reg [SAT_STAGE:SAT_STAGE+DIV_STEPS];
    logic              dv_sat_reg [SAT_STAGE:SAT_STAGE+DIV_STEPS];
    logic [30:0]       sat_lim;
    logic              sat_next;

    logic [14:0]       uref_reg, uref_next;
    logic [16:0]       arg_hi, arg_lo;
    logic [31:0]       g_hi, g_lo;
    logic [31:0]       g1_reg [SIN_DEPTH+1:UREF_STAGE];
    logic [31:0]       g2_reg [SIN_DEPTH+1:UREF_STAGE];

    logic [46:0]       m_t1, m_t2;
    logic [15:0]       t1_reg, t1_next, t2_reg, t2_next;
    logic [16:0]       sum, t0;
    logic [15:0]       h;
    logic [16:0]       ta_reg, ta_next, tb_reg, tb_next, tc_reg, tc_next;
    logic [32:0]       m_a, m_b, m_c;

    // The whole pipeline moves unless a finished word waits at the output.
    assign en    = !(out_valid_reg && out_stall);
    assign rd_en = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= PIPE_LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= rd_valid;
            for (int i = 1; i <= PIPE_LAST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[PIPE_LAST];
        end
    end

    // Entry stage and the sector shift line.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_p0_reg   <= rd_data.mag_sq;
            f_p0_reg   <= rd_data.frac;
            sec_reg[0] <= rd_data.sector;
            for (int i = 1; i <= PIPE_LAST; i++)
            begin
                sec_reg[i] <= sec_reg[i-1];
            end
        end
    end

    // Square root of mag_sq * 2^30, one result bit per stage.
    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_sqrt
            localparam int B = SQRT_STEPS - 1 - k;
            logic [62:0] rem_in, trial, rem_nx;
            logic [30:0] root_in, root_nx;

            if (k == 0)
            begin : g_first
                assign rem_in  = {1'b0, s_p0_reg, 30'd0};
                assign root_in = '0;
            end
            else
            begin : g_rest
                assign rem_in  = sq_rem_reg[k];
                assign root_in = sq_root_reg[k];
            end

            always_comb
            begin
                trial   = ({32'd0, root_in} << (B + 1)) + (63'd1 << (2 * B));
                rem_nx  = rem_in;
                root_nx = root_in;
                if (rem_in >= trial)
                begin
                    rem_nx  = rem_in - trial;
                    root_nx = root_in | (31'd1 << B);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[k+1]  <= rem_nx;
                    sq_root_reg[k+1] <= root_nx;
                end
            end
        end
    endgenerate

    // Saturation test: the quotient passes the limit when root >= limit * V.
    always_comb
    begin
        sat_lim  = {16'd0, UREF_LIMIT} * {15'd0, supply_voltage};
        sat_next = (sq_root_reg[SQRT_STEPS] >= sat_lim);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem_reg[SAT_STAGE] <= sq_root_reg[SQRT_STEPS];
            dv_quo_reg[SAT_STAGE] <= '0;
            dv_sat_reg[SAT_STAGE] <= sat_next;
        end
    end

    // Restoring division, one quotient bit per stage.
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_div
            localparam int B = DIV_STEPS - 1 - k;
            logic [30:0] dsh, rem_nx;
            logic [14:0] quo_nx;

            always_comb
            begin
                dsh    = {15'd0, supply_voltage} << B;
                rem_nx = dv_rem_reg[SAT_STAGE+k];
                quo_nx = dv_quo_reg[SAT_STAGE+k];
                if (dv_rem_reg[SAT_STAGE+k] >= dsh)
                begin
                    rem_nx = dv_rem_reg[SAT_STAGE+k] - dsh;
                    quo_nx = dv_quo_reg[SAT_STAGE+k] | (15'd1 << B);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[SAT_STAGE+k+1] <= rem_nx;
                    dv_quo_reg[SAT_STAGE+k+1] <= quo_nx;
                    dv_sat_reg[SAT_STAGE+k+1] <= dv_sat_reg[SAT_STAGE+k];
                end
            end
        end
    endgenerate

    assign uref_next = dv_sat_reg[SAT_STAGE+DIV_STEPS] ? UREF_MAX
                                                        : dv_quo_reg[SAT_STAGE+DIV_STEPS];

    // Sine lanes for the far and near sector edges.
    assign arg_hi = FULL_FRAC - {1'b0, f_p0_reg};
    assign arg_lo = {1'b0, f_p0_reg};

    ipsv_sin60 u_sin_hi
    (
        .clk (clk),
        .en  (en),
        .arg (arg_hi),
        .g   (g_hi)
    );

    ipsv_sin60 u_sin_lo
    (
        .clk (clk),
        .en  (en),
        .arg (arg_lo),
        .g   (g_lo)
    );

    // Active times and phase times.
    always_comb
    begin
        m_t1    = 47'(g1_reg[UREF_STAGE]) * 47'(uref_reg);
        m_t2    = 47'(g2_reg[UREF_STAGE]) * 47'(uref_reg);
        t1_next = m_t1[45:30];
        t2_next = m_t2[45:30];

        sum = {1'b0, t1_reg} + {1'b0, t2_reg};
        t0  = (sum > ONE_Q15) ? 17'd0 : (ONE_Q15 - sum);
        h   = t0[16:1];
        case (sec_reg[PIPE_LAST-1])
            SECTOR_0:
            begin
                ta_next = sum + {1'b0, h};
                tb_next = {1'b0, t2_reg} + {1'b0, h};
                tc_next = {1'b0, h};
            end
            SECTOR_1:
            begin
                ta_next = {1'b0, t1_reg} + {1'b0, h};
                tb_next = sum + {1'b0, h};
                tc_next = {1'b0, h};
            end
            SECTOR_2:
            begin
                ta_next = {1'b0, h};
                tb_next = sum + {1'b0, h};
                tc_next = {1'b0, t2_reg} + {1'b0, h};
            end
            SECTOR_3:
            begin
                ta_next = {1'b0, h};
                tb_next = {1'b0, t1_reg} + {1'b0, h};
                tc_next = sum + {1'b0, h};
            end
            SECTOR_4:
            begin
                ta_next = {1'b0, t2_reg} + {1'b0, h};
                tb_next = {1'b0, h};
                tc_next = sum + {1'b0, h};
            end
            default:
            begin
                ta_next = sum + {1'b0, h};
                tb_next = {1'b0, h};
                tc_next = {1'b0, t1_reg} + {1'b0, h};
            end
        endcase

        m_a = {16'd0, ta_reg} * {17'd0, timer_period};
        m_b = {16'd0, tb_reg} * {17'd0, timer_period};
        m_c = {16'd0, tc_reg} * {17'd0, timer_period};
        out_data_next.duty_a       = m_a[30:15];
        out_data_next.duty_b       = m_b[30:15];
        out_data_next.duty_c       = m_c[30:15];
        out_data_next.sector_index = sec_reg[PIPE_LAST];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_reg[SIN_DEPTH+1] <= g_hi;
            g2_reg[SIN_DEPTH+1] <= g_lo;
            for (int i = SIN_DEPTH + 2; i <= UREF_STAGE; i++)
            begin
                g1_reg[i] <= g1_reg[i-1];
                g2_reg[i] <= g2_reg[i-1];
            end
            uref_reg     <= uref_next;
            t1_reg       <= t1_next;
            t2_reg       <= t2_next;
            ta_reg       <= ta_next;
            tb_reg       <= tb_next;
            tc_reg       <= tc_next;
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Valid bits move one stage per advance.
    a_vld_shift: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (vld_reg[1] == $past(vld_reg[0])))
        else $error("pipeline valid bits out of step");

    // The modulation index stays within its clamp.
    a_uref_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[UREF_STAGE] |-> (uref_reg <= UREF_MAX))
        else $error("modulation index above clamp");

    // A delivered word always carries one of the six sectors.
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.sector_index <= 3'd5))
        else $error("sector index out of range");

endmodule

[test/tb.sv]
// Testbench for the inverse Park / space vector PWM block.
// Drives random and directed words, predicts each result and compares it.
// Depends on ipsv_pkg and inverse_park_svpwm.
`timescale 1ns / 1ps

module tb;
    import ipsv_pkg::*;

    // Scoreboard: computes expected duty words and checks results in order.
    class duty_scoreboard;
        ipsv_out_t pending[$];
        int errors;
        logic [15:0] bus_volt;
        logic [15:0] period;

        function new();
            errors = 0;
            bus_volt = SUPPLY_RESET;
            period = PERIOD_RESET;
        endfunction

        function automatic logic [63:0] root64(logic [63:0] x);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic logic [63:0] sine60(logic [63:0] f16);
            logic [63:0] f;
            logic [63:0] f2;
            logic [63:0] p;
            f = f16 << 14;
            f2 = (f * f) >> 30;
            p = 64'(C7_Q30) - ((f2 * 64'(C9_Q30)) >> 30);
            p = 64'(C5_Q30) - ((f2 * p) >> 30);
            p = 64'(C3_Q30) - ((f2 * p) >> 30);
            p = 64'(C1_Q30) - ((f2 * p) >> 30);
            return (f * p) >> 30;
        endfunction

        // Work out the result for one accepted input word.
        function void note_input(ipsv_in_t w);
            logic [63:0] q, d, uref, theta, x6, sec, f, t1, t2, t0, h, ta, tb, tc;
            ipsv_out_t e;
            q = (w.volt_q < 0) ? 64'(-32'(w.volt_q)) : 64'(w.volt_q);
            d = (w.volt_d < 0) ? 64'(-32'(w.volt_d)) : 64'(w.volt_d);
            if (bus_volt == 0)
                uref = 64'(UREF_MAX);
            else
                uref = root64((q * q + d * d) << 30) / 64'(bus_volt);
            if (uref > 64'(UREF_MAX)) uref = 64'(UREF_MAX);
            theta = (64'(w.elec_angle) + 64'd16384) & 64'hFFFF;
            x6 = theta * 6;
            sec = x6 >> 16;
            f = x6 & 64'hFFFF;
            t1 = (sine60(64'd65536 - f) * uref) >> 30;
            t2 = (sine60(f) * uref) >> 30;
            t0 = (t1 + t2 > 64'd32768) ? 64'd0 : 64'd32768 - t1 - t2;
            h = t0 >> 1;
            case (3'(sec))
                SECTOR_0: begin ta = t1 + t2 + h; tb = t2 + h; tc = h; end
                SECTOR_1: begin ta = t1 + h; tb = t1 + t2 + h; tc = h; end
                SECTOR_2: begin ta = h; tb = t1 + t2 + h; tc = t2 + h; end
                SECTOR_3: begin ta = h; tb = t1 + h; tc = t1 + t2 + h; end
                SECTOR_4: begin ta = t2 + h; tb = h; tc = t1 + t2 + h; end
                default:  begin ta = t1 + t2 + h; tb = h; tc = t1 + h; end
            endcase
            e.duty_a = 16'((ta * period) >> 15);
            e.duty_b = 16'((tb * period) >> 15);
            e.duty_c = 16'((tc * period) >> 15);
            e.sector_index = 3'(sec);
            pending.push_back(e);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        // Compare one result word with the oldest expectation.
        task check_result(ipsv_out_t r);
            ipsv_out_t e;
            if (pending.size() == 0)
            begin
                report("unexpected word", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (r.duty_a !== e.duty_a) report("duty_a", r.duty_a, e.duty_a);
            if (r.duty_b !== e.duty_b) report("duty_b", r.duty_b, e.duty_b);
            if (r.duty_c !== e.duty_c) report("duty_c", r.duty_c, e.duty_c);
            if (r.sector_index !== e.sector_index)
                report("sector_index", r.sector_index, e.sector_index);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    ipsv_in_t in_data;
    logic out_valid;
    logic out_stall;
    ipsv_out_t out_data;
    logic cfg_wr_en;
    logic [0:0] cfg_index;
    logic [15:0] cfg_data;

    duty_scoreboard board;
    bit stall_quiet;

    inverse_park_svpwm uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly short, sometimes long.
    function automatic int gap_len();
        if ($urandom_range(9) == 0) return $urandom_range(40, 5);
        if ($urandom_range(2) == 0) return 0;
        return $urandom_range(2);
    endfunction

    // Check results at the rising edge.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);

    // Receiver stall pattern, changed at the falling edge.
    initial
    begin
        int n;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall_quiet || $urandom_range(3) != 0)
                out_stall <= 0;
            else
            begin
                n = gap_len() + 1;
                out_stall <= 1;
                repeat (n) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    // Present one word and hold it until accepted.
    task send_word(ipsv_in_t w, bit busy);
        int n;
        n = busy ? 0 : gap_len();
        if (n != 0)
        begin
            in_valid <= 0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1;
        in_data <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_input(w);
        @(negedge clk);
    endtask

    task drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        @(negedge clk);
    endtask

    task write_reg(logic [0:0] idx, logic [15:0] value);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_wr_en <= 0;
        if (idx == REG_SUPPLY) board.bus_volt = value;
        else board.period = value;
        @(negedge clk);
    endtask

    function automatic ipsv_in_t rand_word();
        ipsv_in_t w;
        w.volt_q = 16'($urandom);
        w.volt_d = 16'($urandom);
        w.elec_angle = 16'($urandom);
        if ($urandom_range(3) == 0)
        begin
            w.volt_q = 16'($signed(16'($urandom_range(1000))) - 16'sd500);
            w.volt_d = 16'($signed(16'($urandom_range(1000))) - 16'sd500);
        end
        return w;
    endfunction

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence: directed corners, then random words across settings.
    initial
    begin
        ipsv_in_t w;
        logic [15:0] volts[6];
        logic [15:0] periods[6];
        board = new();
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_wr_en = 0;
        cfg_index = REG_SUPPLY;
        cfg_data = 0;
        stall_quiet = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Field extremes and sector boundaries at the reset settings.
        for (int i = 0; i < 8; i++)
        begin
            w.volt_q = (i % 3 == 0) ? -16'sd32768 : (i % 3 == 1) ? 16'sd32767 : 16'sd0;
            w.volt_d = (i % 2) ? -16'sd32768 : 16'sd0;
            w.elec_angle = 16'(i * 10923);
            send_word(w, 0);
        end
        w = '{16'sd256, 16'sd0, 16'hFFFF};
        send_word(w, 0);
        w = '{16'sd0, 16'sd0, 16'h0000};
        send_word(w, 0);
        w = '{-16'sd1, 16'sd1, 16'h4000};
        send_word(w, 0);
        drain();

        // Zero bus voltage saturates; minimum period; large period.
        volts = '{16'd0, 16'd1, 16'd65535, 16'd3072, 16'd200, 16'd9000};
        periods = '{16'd100, 16'd65535, 16'd1, 16'd0, 16'd4000, 16'd100};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_SUPPLY, volts[p]);
            write_reg(REG_PERIOD, periods[p]);
            for (int i = 0; i < 200; i++)
            begin
                // Stretches with no gaps on either side.
                stall_quiet = (i >= 100 && i < 140);
                send_word(rand_word(), stall_quiet);
                if (i == 150)
                begin
                    // Hold off until every outstanding result is back.
                    in_valid <= 0;
                    while (board.pending.size() != 0) @(posedge clk);
                    @(negedge clk);
                end
            end
            stall_quiet = 0;
            drain();
        end

        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
